### hdl/npcs_pkg.sv
package npcs_pkg;

    localparam int PALETTE_ENTRIES = 256;
    localparam int NUM_CELLS       = PALETTE_ENTRIES - 1;
    localparam int IDX_W           = 8;
    localparam int CH_W            = 8;
    localparam int SQ_W            = 2 * CH_W;
    localparam int DIST_W          = 18;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_PIXEL = 1'b1;

    localparam logic [DIST_W-1:0] DIST_LIMIT = 18'd195075;
    localparam logic [DIST_W-1:0] DIST_NONE  = '1;

    typedef struct packed {
        logic              mode;
        logic [IDX_W-1:0]  entry_index;
        logic [CH_W-1:0]   red;
        logic [CH_W-1:0]   green;
        logic [CH_W-1:0]   blue;
        logic [IDX_W-1:0]  best_idx;
        logic [DIST_W-1:0] best_dist;
        logic [DIST_W-1:0] cand_dist;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_flow;

    function automatic logic [SQ_W-1:0] sq_diff(input logic [CH_W-1:0] a,
                                                input logic [CH_W-1:0] b);
        logic [CH_W-1:0] d;
        d = (a >= b) ? (a - b) : (b - a);
        return SQ_W'(d) * SQ_W'(d);
    endfunction

endpackage

### hdl/npcs_if.sv
interface npcs_req_if import npcs_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             mode;
    logic [IDX_W-1:0] entry_index;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;

    modport source (output valid, mode, entry_index, red, green, blue, input ready);
    modport sink   (input valid, mode, entry_index, red, green, blue, output ready);
endinterface

interface npcs_rsp_if import npcs_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  color_index;
    logic [DIST_W-1:0] best_distance;

    modport source (output valid, color_index, best_distance, input ready);
    modport sink   (input valid, color_index, best_distance, output ready);
endinterface

### hdl/npcs_cell.sv
module npcs_cell import npcs_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_advance,
    input  logic [IDX_W-1:0] i_cell_index,
    input  t_flow            i_flow,
    output t_flow            o_flow
);

    logic [3*CH_W-1:0] r_entry;
    logic              r_valid;
    t_item             r_item;
    t_item             n_item;
    logic [DIST_W-1:0] w_dist;

    assign w_dist = DIST_W'(sq_diff(i_flow.item.red,   r_entry[3*CH_W-1:2*CH_W]))
                  + DIST_W'(sq_diff(i_flow.item.green, r_entry[2*CH_W-1:CH_W]))
                  + DIST_W'(sq_diff(i_flow.item.blue,  r_entry[CH_W-1:0]));

    always_comb begin
        n_item           = i_flow.item;
        n_item.cand_dist = w_dist;
        if (i_flow.item.cand_dist < i_flow.item.best_dist) begin
            n_item.best_dist = i_flow.item.cand_dist;
            n_item.best_idx  = i_cell_index - IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_advance) begin
            r_valid <= i_flow.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_item <= n_item;
            if (i_flow.valid && i_flow.item.mode == MODE_LOAD
                    && i_flow.item.entry_index == i_cell_index) begin
                r_entry <= {i_flow.item.red, i_flow.item.green, i_flow.item.blue};
            end
        end
    end

    assign o_flow = '{valid: r_valid, item: r_item};

endmodule

### hdl/npcs_out.sv
module npcs_out import npcs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_flow             i_flow,
    input  logic              i_ready,
    output logic              o_advance,
    output logic              o_valid,
    output logic [IDX_W-1:0]  o_color_index,
    output logic [DIST_W-1:0] o_best_distance
);

    logic              r_valid;
    logic [IDX_W-1:0]  r_idx;
    logic [DIST_W-1:0] r_dist;
    logic [IDX_W-1:0]  n_idx;
    logic [DIST_W-1:0] n_dist;

    assign o_advance = !r_valid || i_ready;

    always_comb begin
        n_idx  = i_flow.item.best_idx;
        n_dist = i_flow.item.best_dist;
        if (i_flow.item.cand_dist < i_flow.item.best_dist) begin
            n_idx  = IDX_W'(NUM_CELLS);
            n_dist = i_flow.item.cand_dist;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_flow.valid && i_flow.item.mode == MODE_PIXEL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance) begin
            r_idx  <= n_idx;
            r_dist <= n_dist;
        end
    end

    assign o_valid         = r_valid;
    assign o_color_index   = r_idx;
    assign o_best_distance = r_dist;

`ifndef NO_ASSERTIONS
    a_idx_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> r_idx != '0)
        else $error("entry zero chosen");

    a_dist_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> r_dist <= DIST_LIMIT)
        else $error("distance out of range");

    a_pixel_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_advance && i_flow.valid && i_flow.item.mode == MODE_PIXEL) |=> r_valid)
        else $error("pixel request lost at chain end");
`endif

endmodule

### hdl/nearest_palette_color_search.sv
// A request goes through each palette cell, then the output register; output stalls hold it.
// Throughput: one request per cycle unless stalled; each palette cell steps once per request.
// Loads travel the chain in order with pixels, so a pixel sees every earlier load.
// Backpressure on the result holds the whole chain.
// Reset clears the valid flags only; palette entries stay undefined until loaded.
module nearest_palette_color_search import npcs_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    npcs_req_if.sink   i_req,
    npcs_rsp_if.source o_rsp
);

    t_flow w_flow [0:NUM_CELLS];
    logic  w_advance;

    assign i_req.ready = w_advance;

    assign w_flow[0] = '{
        valid: i_req.valid,
        item: '{
            mode:        i_req.mode,
            entry_index: i_req.entry_index,
            red:         i_req.red,
            green:       i_req.green,
            blue:        i_req.blue,
            best_idx:    IDX_W'(1),
            best_dist:   DIST_NONE,
            cand_dist:   DIST_NONE
        }
    };

    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        npcs_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_advance    (w_advance),
            .i_cell_index (IDX_W'(g + 1)),
            .i_flow       (w_flow[g]),
            .o_flow       (w_flow[g+1])
        );
    end

    npcs_out u_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_flow          (w_flow[NUM_CELLS]),
        .i_ready         (o_rsp.ready),
        .o_advance       (w_advance),
        .o_valid         (o_rsp.valid),
        .o_color_index   (o_rsp.color_index),
        .o_best_distance (o_rsp.best_distance)
    );

endmodule

### tb/nearest_palette_color_search_tb.sv
`timescale 1ns / 1ps

module nearest_palette_color_search_tb import npcs_pkg::*; ();

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int          PHASE_ITEMS = 70;

    typedef struct {
        logic [IDX_W-1:0]  color_index;
        logic [DIST_W-1:0] best_distance;
    } t_color_match;

    class color_match_board;
        logic [3*CH_W-1:0] palette [PALETTE_ENTRIES];
        t_color_match      expected_matches [$];
        int unsigned       failures;

        function new();
            failures = 0;
            foreach (palette[k]) palette[k] = '0;
        endfunction

        function t_color_match nearest_entry(logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                                             logic [CH_W-1:0] b);
            t_color_match m;
            int unsigned  sq_sum;
            int unsigned  best;
            int           dr;
            int           dg;
            int           db;
            int           p;
            best = 32'hFFFF_FFFF;
            m.color_index = IDX_W'(1);
            for (p = 1; p < PALETTE_ENTRIES; p++) begin
                dr = int'(r) - int'(palette[p][23:16]);
                dg = int'(g) - int'(palette[p][15:8]);
                db = int'(b) - int'(palette[p][7:0]);
                sq_sum = dr * dr + dg * dg + db * db;
                // strict compare keeps the lowest index on a tie
                if (sq_sum < best) begin
                    best = sq_sum;
                    m.color_index = IDX_W'(p);
                end
            end
            m.best_distance = DIST_W'(best);
            return m;
        endfunction

        function void note_request(logic mode, logic [IDX_W-1:0] slot, logic [CH_W-1:0] r,
                                   logic [CH_W-1:0] g, logic [CH_W-1:0] b);
            if (mode == MODE_LOAD) begin
                if (int'(slot) < PALETTE_ENTRIES) begin
                    palette[slot] = {r, g, b};
                end
            end else begin
                expected_matches.push_back(nearest_entry(r, g, b));
            end
        endfunction

        function void check_result(logic [IDX_W-1:0] idx, logic [DIST_W-1:0] distance);
            t_color_match want;
            if (expected_matches.size() == 0) begin
                failures++;
                if (failures <= 10) begin
                    $display("unexpected result: index %0d distance %0d", idx, distance);
                end
                return;
            end
            want = expected_matches.pop_front();
            if (idx !== want.color_index || distance !== want.best_distance) begin
                failures++;
                if (failures <= 10) begin
                    $display("mismatch: index exp %0d got %0d, distance exp %0d got %0d",
                             want.color_index, idx, want.best_distance, distance);
                end
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    npcs_req_if req_if ();
    npcs_rsp_if rsp_if ();

    nearest_palette_color_search dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    color_match_board sb;
    int unsigned      cycles         = 0;
    int               src_idle_pct   = 0;
    int               sink_stall_pct = 0;

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("nearest_palette_color_search verification failed");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        rsp_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            sb.check_result(rsp_if.color_index, rsp_if.best_distance);
        end
    end

    task automatic send_request(input logic mode, input logic [IDX_W-1:0] slot,
                                input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                                input logic [CH_W-1:0] b);
        while ($urandom_range(99) < src_idle_pct) begin
            req_if.valid = 1'b0;
            @(negedge i_clk);
        end
        req_if.valid       = 1'b1;
        req_if.mode        = mode;
        req_if.entry_index = slot;
        req_if.red         = r;
        req_if.green       = g;
        req_if.blue        = b;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        sb.note_request(mode, slot, r, g, b);
        @(negedge i_clk);
    endtask

    function automatic logic [CH_W-1:0] near_byte(logic [CH_W-1:0] v);
        int t;
        t = int'(v) + int'($urandom_range(6)) - 3;
        if (t < 0) t = 0;
        if (t > 255) t = 255;
        return CH_W'(t);
    endfunction

    initial begin
        logic [CH_W-1:0]   r;
        logic [CH_W-1:0]   g;
        logic [CH_W-1:0]   b;
        logic [3*CH_W-1:0] entry;
        int                ph;
        int                k;

        sb                 = new();
        i_rst_n            = 1'b0;
        req_if.valid       = 1'b0;
        req_if.mode        = MODE_LOAD;
        req_if.entry_index = '0;
        req_if.red         = '0;
        req_if.green       = '0;
        req_if.blue        = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // random palette, every slot loaded before any pixel
        for (k = 0; k < PALETTE_ENTRIES; k++) begin
            {r, g, b} = 24'($urandom);
            send_request(MODE_LOAD, IDX_W'(k), r, g, b);
        end

        send_request(MODE_PIXEL, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_request(MODE_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00);
        send_request(MODE_LOAD,  8'h00, 8'd10, 8'd20, 8'd30);
        send_request(MODE_PIXEL, 8'h5A, 8'd10, 8'd20, 8'd30);
        send_request(MODE_LOAD,  8'd200, 8'd10, 8'd20, 8'd30);
        send_request(MODE_LOAD,  8'd50, 8'd10, 8'd20, 8'd30);
        send_request(MODE_PIXEL, 8'hA5, 8'd10, 8'd20, 8'd30);
        send_request(MODE_PIXEL, 8'h00, 8'd12, 8'd20, 8'd30);
        send_request(MODE_LOAD,  8'd255, 8'hFF, 8'hFF, 8'hFF);
        send_request(MODE_PIXEL, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_request(MODE_PIXEL, 8'h01, 8'd250, 8'd250, 8'd250);
        send_request(MODE_LOAD,  8'd1, 8'd11, 8'd20, 8'd30);
        send_request(MODE_PIXEL, 8'h80, 8'd12, 8'd20, 8'd30);
        send_request(MODE_PIXEL, 8'h7F, 8'hFF, 8'h00, 8'hFF);

        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 81; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 81; end
                default: begin src_idle_pct = 15; sink_stall_pct = 15; end
            endcase
            repeat (PHASE_ITEMS) begin
                if ($urandom_range(99) < 35) begin
                    if ($urandom_range(3) == 0) begin
                        {r, g, b} = sb.palette[$urandom_range(PALETTE_ENTRIES - 1)];
                    end else begin
                        {r, g, b} = 24'($urandom);
                    end
                    send_request(MODE_LOAD, IDX_W'($urandom), r, g, b);
                end else begin
                    entry = sb.palette[$urandom_range(PALETTE_ENTRIES - 1, 1)];
                    case ($urandom_range(3))
                        0: {r, g, b} = 24'($urandom);
                        1: {r, g, b} = entry;
                        2: begin
                            r = near_byte(entry[23:16]);
                            g = near_byte(entry[15:8]);
                            b = near_byte(entry[7:0]);
                        end
                        default: begin
                            r = $urandom_range(1) ? 8'hFF : 8'h00;
                            g = $urandom_range(1) ? 8'hFF : 8'h00;
                            b = $urandom_range(1) ? 8'hFF : 8'h00;
                        end
                    endcase
                    send_request(MODE_PIXEL, IDX_W'($urandom), r, g, b);
                end
            end
        end
        req_if.valid = 1'b0;

        while (sb.expected_matches.size() != 0) @(posedge i_clk);
        repeat (NUM_CELLS + 16) @(posedge i_clk);

        if (sb.failures == 0) begin
            $display("nearest_palette_color_search verification clean");
        end else begin
            $display("nearest_palette_color_search verification failed");
        end
        $finish;
    end

endmodule

### sim.f
hdl/npcs_pkg.sv
hdl/npcs_if.sv
hdl/npcs_cell.sv
hdl/npcs_out.sv
hdl/nearest_palette_color_search.sv
tb/nearest_palette_color_search_tb.sv
